@@ sv/ptd_pkg.sv @@
// Shared opcodes and unit interface types for the periodic task dispatcher.
package ptd_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_RUN     = 3'd1;
    localparam logic [2:0] OP_ADD     = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;
    localparam logic [2:0] OP_ENABLE  = 3'd5;

    localparam int TICK_W = 32;

    typedef struct packed {
        logic              sub;
        logic [TICK_W-1:0] a;
        logic [TICK_W-1:0] b;
        logic [TICK_W-1:0] lim;
    } alu_req_t;

    typedef struct packed {
        logic [TICK_W-1:0] sum;
        logic              ge;
    } alu_rsp_t;

endpackage

@@ sv/ptd_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module ptd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ptd_alu.sv @@
// Shared 32-bit unit: tick increment, or elapsed-tick subtraction with period compare.
module ptd_alu
    import ptd_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [TICK_W-1:0] sum;

    // Subtraction wraps modulo 2^32, which is exactly the elapsed tick count.
    assign sum     = req.sub ? (req.a - req.b) : (req.a + TICK_W'(1));
    assign rsp.sum = sum;
    assign rsp.ge  = (sum >= req.lim);

endmodule

@@ sv/periodic_task_dispatcher_core.sv @@
// Periodic task dispatcher: a ring of task slots served round robin against a tick counter.
// Every item gives exactly one result. Tick, add, restart, enable and unused-opcode items,
// a run step with no current task and a remove of an unused slot go from S_EXEC straight
// to S_DONE, which presents the result. A run step with a current task goes through S_RUN
// between the two, since it reads the slot's period, last tick and link from RAM and then
// uses the shared subtract-and-compare unit. A remove of a used slot goes through S_RMV,
// then, unless the slot is the head, through S_WALK, which walks the link RAM one entry per
// cycle to find the predecessor, and then through S_RMEND to S_DONE. One item is in work
// at a time; a finished result waits in the output register while the next item is taken,
// and an item that finishes while that register is still full waits until it is free.
module periodic_task_dispatcher_core
    import ptd_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [3:0]  task_slot,
    input  logic [31:0] task_period,
    input  logic        enable_flag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        fired,
    output logic [3:0]  fired_slot,
    output logic [31:0] tick_now
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int SW = $clog2(MAX_TASKS + 1);
    localparam logic [SW-1:0] NIL = SW'(MAX_TASKS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_RMV   = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_RMEND = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [3:0]           slot_reg, slot_next;
    logic [31:0]          period_reg, period_next;
    logic                 en_reg, en_next;
    logic [31:0]          tick_reg, tick_next;
    logic [MAX_TASKS-1:0] used_reg, used_next;
    logic [MAX_TASKS-1:0] dis_reg, dis_next;
    logic [SW-1:0]        head_reg, head_next;
    logic [SW-1:0]        cur_reg, cur_next;
    logic [SW-1:0]        walk_reg, walk_next;
    logic [SW-1:0]        link_s_reg, link_s_next;
    logic [SW-1:0]        guard_reg, guard_next;
    logic                 res_fired_reg, res_fired_next;
    logic [3:0]           res_slot_reg, res_slot_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 fired_reg, fired_next;
    logic [3:0]           fired_slot_reg, fired_slot_next;
    logic [31:0]          tick_now_reg, tick_now_next;

    logic [IW-1:0] ram_raddr, ram_waddr;
    logic          per_we, last_we, link_we;
    logic [31:0]   last_wdata;
    logic [SW-1:0] link_wdata;
    logic [31:0]   period_q, last_q;
    logic [SW-1:0] link_q;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic          slot_ok;
    logic [IW-1:0] sidx, cidx;
    logic [SW-1:0] s_sw, nxt, guard_inc;

    ptd_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (ram_waddr),
        .wdata (period_reg),
        .raddr (ram_raddr),
        .rdata (period_q)
    );

    ptd_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_last_ram (
        .clk   (clk),
        .we    (last_we),
        .waddr (ram_waddr),
        .wdata (last_wdata),
        .raddr (ram_raddr),
        .rdata (last_q)
    );

    ptd_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (ram_waddr),
        .wdata (link_wdata),
        .raddr (ram_raddr),
        .rdata (link_q)
    );

    ptd_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign slot_ok   = (32'(slot_reg) < 32'(MAX_TASKS));
    assign sidx      = IW'(slot_reg);
    assign cidx      = IW'(cur_reg);
    assign s_sw      = SW'(slot_reg);
    assign guard_inc = guard_reg + SW'(1);
    // Successor of the slot whose link is on the RAM output, wrapping to the head.
    assign nxt       = (link_q < NIL) ? link_q : head_reg;

    assign alu_req.sub = (state_reg == S_RUN);
    assign alu_req.a   = tick_reg;
    assign alu_req.b   = last_q;
    assign alu_req.lim = period_q;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign fired      = fired_reg;
    assign fired_slot = fired_slot_reg;
    assign tick_now   = tick_now_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        period_next     = period_reg;
        en_next         = en_reg;
        tick_next       = tick_reg;
        used_next       = used_reg;
        dis_next        = dis_reg;
        head_next       = head_reg;
        cur_next        = cur_reg;
        walk_next       = walk_reg;
        link_s_next     = link_s_reg;
        guard_next      = guard_reg;
        res_fired_next  = res_fired_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        fired_next      = fired_reg;
        fired_slot_next = fired_slot_reg;
        tick_now_next   = tick_now_reg;
        ram_raddr       = sidx;
        ram_waddr       = sidx;
        per_we          = 1'b0;
        last_we         = 1'b0;
        link_we         = 1'b0;
        last_wdata      = tick_reg;
        link_wdata      = head_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = opcode;
                    slot_next   = task_slot;
                    period_next = task_period;
                    en_next     = enable_flag;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_fired_next = 1'b0;
                res_slot_next  = 4'd0;
                state_next     = S_DONE;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        tick_next = alu_rsp.sum;
                    end
                    OP_RUN:
                    begin
                        if (cur_reg < NIL)
                        begin
                            ram_raddr  = cidx;
                            state_next = S_RUN;
                        end
                    end
                    OP_ADD:
                    begin
                        if (slot_ok && !used_reg[sidx])
                        begin
                            per_we          = 1'b1;
                            last_we         = 1'b1;
                            link_we         = 1'b1;
                            used_next[sidx] = 1'b1;
                            dis_next[sidx]  = !en_reg;
                            head_next       = s_sw;
                            if (!(cur_reg < NIL))
                            begin
                                cur_next = s_sw;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (slot_ok && used_reg[sidx])
                        begin
                            state_next = S_RMV;
                        end
                    end
                    OP_RESTART:
                    begin
                        if (slot_ok && used_reg[sidx])
                        begin
                            last_we = 1'b1;
                        end
                    end
                    OP_ENABLE:
                    begin
                        if (slot_ok && used_reg[sidx])
                        begin
                            dis_next[sidx] = !en_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RUN:
            begin
                res_slot_next = 4'(cur_reg);
                if (!dis_reg[cidx] && alu_rsp.ge)
                begin
                    res_fired_next = 1'b1;
                    ram_waddr      = cidx;
                    last_we        = 1'b1;
                end
                cur_next   = nxt;
                state_next = S_DONE;
            end
            S_RMV:
            begin
                // The link of the removed slot is on the RAM output.
                link_s_next = link_q;
                if (cur_reg == s_sw)
                begin
                    cur_next = (nxt == s_sw) ? NIL : nxt;
                end
                if (head_reg == s_sw)
                begin
                    head_next  = link_q;
                    state_next = S_RMEND;
                end
                else if (head_reg < NIL)
                begin
                    walk_next  = head_reg;
                    guard_next = '0;
                    ram_raddr  = IW'(head_reg);
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_RMEND;
                end
            end
            S_WALK:
            begin
                // Each cycle the link of walk_reg arrives and the next read is issued at once.
                if (link_q == s_sw)
                begin
                    ram_waddr  = IW'(walk_reg);
                    link_wdata = link_s_reg;
                    link_we    = 1'b1;
                    state_next = S_RMEND;
                end
                else
                begin
                    walk_next  = link_q;
                    guard_next = guard_inc;
                    if ((guard_inc < NIL) && (link_q < NIL))
                    begin
                        ram_raddr = IW'(link_q);
                    end
                    else
                    begin
                        state_next = S_RMEND;
                    end
                end
            end
            S_RMEND:
            begin
                used_next[sidx] = 1'b0;
                dis_next[sidx]  = 1'b0;
                if (!(head_reg < NIL))
                begin
                    cur_next = NIL;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    fired_next      = res_fired_reg;
                    fired_slot_next = res_slot_reg;
                    tick_now_next   = tick_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            used_reg      <= '0;
            dis_reg       <= '0;
            head_reg      <= NIL;
            cur_reg       <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            used_reg      <= used_next;
            dis_reg       <= dis_next;
            head_reg      <= head_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        slot_reg       <= slot_next;
        period_reg     <= period_next;
        en_reg         <= en_next;
        walk_reg       <= walk_next;
        link_s_reg     <= link_s_next;
        guard_reg      <= guard_next;
        res_fired_reg  <= res_fired_next;
        res_slot_reg   <= res_slot_next;
        fired_reg      <= fired_next;
        fired_slot_reg <= fired_slot_next;
        tick_now_reg   <= tick_now_next;
    end

`ifndef ASSERT_OFF
    // Between items there is a current task exactly when the ring is not empty.
    a_cur_iff_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((cur_reg == NIL) == (head_reg == NIL)))
        else $error("current task and list head disagree on an empty ring");

    // Between items the head of the ring is always a slot in use.
    a_head_used: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && (head_reg != NIL)) |-> used_reg[IW'(head_reg)])
        else $error("list head names an unused slot");

    // Between items the current task is always a slot in use.
    a_cur_used: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && (cur_reg != NIL)) |-> used_reg[IW'(cur_reg)])
        else $error("current task names an unused slot");

    // A result is loaded only from the final state of an item.
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the completion state");
`endif

endmodule
